@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define DPWG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define DPWG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/dpwg_pkg.sv @@
// Types and constants shared by the delay phase weight generator modules.
package dpwg_pkg;

    localparam int FREQ_W      = 27;
    localparam int DELAY_W     = 32;
    localparam int RATE_W      = 33;
    localparam int PHASE_BITS  = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int NUM_CELLS   = 5;

    // 2^52 / 80 MHz
    localparam logic [RATE_W-1:0] RATE_RESET = 33'd56294995;
    // pi/4 in Q0.32
    localparam logic [31:0] PI4_Q32 = 32'd3373259426;
    // 1.0 in Q1.32
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef struct packed {
        logic [FREQ_W-1:0]         frequency_hz;
        logic signed [DELAY_W-1:0] delay_samples;
    } dpwg_in_t;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight_real;
        logic signed [WEIGHT_BITS-1:0] weight_imag;
    } dpwg_out_t;

    // Word handed from one series cell to the next.
    typedef struct packed {
        logic        valid;
        logic [2:0]  oct;
        logic [31:0] x2;
        logic [32:0] term_s;
        logic [32:0] term_c;
        logic [32:0] sum_s;
        logic [32:0] sum_c;
    } dpwg_cell_t;

endpackage

@@ rtl/dpwg_taylor_cell.sv @@
// One Taylor series cell: next sine and cosine term, added into or subtracted from the running sums.
module dpwg_taylor_cell #(
    parameter int K = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  dpwg_pkg::dpwg_cell_t cell_in,
    output dpwg_pkg::dpwg_cell_t cell_out
);

    localparam int DIV_S = (2 * K) * (2 * K + 1);
    localparam int DIV_C = (2 * K - 1) * (2 * K);
    localparam logic [31:0] RECIP_S = 32'((64'd1 << 32) / DIV_S);
    localparam logic [31:0] RECIP_C = 32'((64'd1 << 32) / DIV_C);
    localparam bit ADD_TERM = ((K % 2) == 0);

    // stage a: term times x^2
    logic        a_valid_reg, a_valid_next;
    logic [2:0]  a_oct_reg;
    logic [31:0] a_x2_reg;
    logic [31:0] a_ns_reg, a_ns_next;
    logic [31:0] a_nc_reg, a_nc_next;
    logic [32:0] a_sum_s_reg, a_sum_c_reg;
    // stage b: reciprocal estimate of the quotient
    logic        b_valid_reg;
    logic [2:0]  b_oct_reg;
    logic [31:0] b_x2_reg;
    logic [31:0] b_ns_reg, b_nc_reg;
    logic [31:0] b_qs_reg, b_qs_next;
    logic [31:0] b_qc_reg, b_qc_next;
    logic [32:0] b_sum_s_reg, b_sum_c_reg;
    // stage c: corrected quotient and sums
    logic        c_valid_reg;
    logic [2:0]  c_oct_reg;
    logic [31:0] c_x2_reg;
    logic [32:0] c_ts_reg, c_ts_next;
    logic [32:0] c_tc_reg, c_tc_next;
    logic [32:0] c_sum_s_reg, c_sum_s_next;
    logic [32:0] c_sum_c_reg, c_sum_c_next;

    logic [64:0] prod_s, prod_c;
    logic [63:0] est_s, est_c;
    logic [39:0] rem_s, rem_c;
    logic [31:0] q_s, q_c;

    always_comb begin
        a_valid_next = cell_in.valid;
        prod_s = 65'(cell_in.term_s) * 65'(cell_in.x2);
        prod_c = 65'(cell_in.term_c) * 65'(cell_in.x2);
        a_ns_next = prod_s[63:32];
        a_nc_next = prod_c[63:32];

        est_s = 64'(a_ns_reg) * 64'(RECIP_S);
        est_c = 64'(a_nc_reg) * 64'(RECIP_C);
        b_qs_next = est_s[63:32];
        b_qc_next = est_c[63:32];

        // estimate is low by at most one
        rem_s = 40'(b_ns_reg) - 40'(b_qs_reg) * 40'(DIV_S);
        rem_c = 40'(b_nc_reg) - 40'(b_qc_reg) * 40'(DIV_C);
        q_s = (rem_s >= 40'(DIV_S)) ? b_qs_reg + 32'd1 : b_qs_reg;
        q_c = (rem_c >= 40'(DIV_C)) ? b_qc_reg + 32'd1 : b_qc_reg;
        c_ts_next = 33'(q_s);
        c_tc_next = 33'(q_c);
        if (ADD_TERM) begin
            c_sum_s_next = b_sum_s_reg + 33'(q_s);
            c_sum_c_next = b_sum_c_reg + 33'(q_c);
        end else begin
            c_sum_s_next = b_sum_s_reg - 33'(q_s);
            c_sum_c_next = b_sum_c_reg - 33'(q_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_oct_reg   <= cell_in.oct;
            a_x2_reg    <= cell_in.x2;
            a_ns_reg    <= a_ns_next;
            a_nc_reg    <= a_nc_next;
            a_sum_s_reg <= cell_in.sum_s;
            a_sum_c_reg <= cell_in.sum_c;

            b_oct_reg   <= a_oct_reg;
            b_x2_reg    <= a_x2_reg;
            b_ns_reg    <= a_ns_reg;
            b_nc_reg    <= a_nc_reg;
            b_qs_reg    <= b_qs_next;
            b_qc_reg    <= b_qc_next;
            b_sum_s_reg <= a_sum_s_reg;
            b_sum_c_reg <= a_sum_c_reg;

            c_oct_reg   <= b_oct_reg;
            c_x2_reg    <= b_x2_reg;
            c_ts_reg    <= c_ts_next;
            c_tc_reg    <= c_tc_next;
            c_sum_s_reg <= c_sum_s_next;
            c_sum_c_reg <= c_sum_c_next;
        end
    end

    always_comb begin
        cell_out.valid  = c_valid_reg;
        cell_out.oct    = c_oct_reg;
        cell_out.x2     = c_x2_reg;
        cell_out.term_s = c_ts_reg;
        cell_out.term_c = c_tc_reg;
        cell_out.sum_s  = c_sum_s_reg;
        cell_out.sum_c  = c_sum_c_reg;
    end

endmodule

@@ rtl/dpwg_phase.sv @@
// Phase front end: f*delay*recip product, phase wrap, octant fold and x, x^2.
module dpwg_phase #(
    parameter int PHASE_BITS = dpwg_pkg::PHASE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  dpwg_pkg::dpwg_in_t              in_data,
    input  logic [dpwg_pkg::RATE_W-1:0]     inv_rate,
    output dpwg_pkg::dpwg_cell_t            cell_out
);

    localparam int R_W     = PHASE_BITS - 2;
    localparam int X_SHIFT = 35 - PHASE_BITS;
    localparam logic [R_W-1:0] NSUB = {1'b1, {(R_W - 1){1'b0}}};

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [58:0]     prod_reg, prod_next;
    logic [63:0]            pll_reg, pll_next;
    logic [39:0]            phl_reg, phl_next;
    logic [39:0]            pfix_reg, pfix_next;
    logic [PHASE_BITS-1:0]  ph_reg, ph_next;
    logic [2:0]             oct4_reg, oct5_reg;
    logic [31:0]            x_reg, x_next;
    logic [31:0]            x5_reg;
    logic [31:0]            x2_reg, x2_next;

    logic signed [59:0]     phl_full;
    logic [39:0]            hi40;
    logic [2:0]             oct;
    logic [R_W-1:0]         r_adj;
    logic [32:0]            x_scaled;
    logic [63:0]            x_prod;
    logic [63:0]            sq_prod;

    always_comb begin
        prod_next = 59'($signed({1'b0, in_data.frequency_hz})) * 59'(in_data.delay_samples);

        // only bits below 2^72 matter: the phase wraps there
        pll_next  = 64'(prod_reg[31:0]) * 64'(inv_rate[31:0]);
        phl_full  = 60'($signed(prod_reg[58:32])) * 60'($signed({1'b0, inv_rate[31:0]}));
        phl_next  = phl_full[39:0];
        pfix_next = inv_rate[32] ? prod_reg[39:0] : 40'd0;

        hi40    = 40'(pll_reg[63:32]) + phl_reg + pfix_reg;
        ph_next = hi40[39 -: PHASE_BITS];

        // mirror odd octants
        oct      = ph_reg[PHASE_BITS-1 -: 3];
        r_adj    = oct[0] ? NSUB - {1'b0, ph_reg[PHASE_BITS-4:0]}
                          : {1'b0, ph_reg[PHASE_BITS-4:0]};
        x_scaled = 33'(r_adj) << X_SHIFT;
        x_prod   = 64'(x_scaled) * 64'(dpwg_pkg::PI4_Q32);
        x_next   = x_prod[63:32];

        sq_prod = 64'(x_reg) * 64'(x_reg);
        x2_next = sq_prod[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            pll_reg  <= pll_next;
            phl_reg  <= phl_next;
            pfix_reg <= pfix_next;
            ph_reg   <= ph_next;
            oct4_reg <= oct;
            x_reg    <= x_next;
            oct5_reg <= oct4_reg;
            x5_reg   <= x_reg;
            x2_reg   <= x2_next;
        end
    end

    always_comb begin
        cell_out.valid  = v5_reg;
        cell_out.oct    = oct5_reg;
        cell_out.x2     = x2_reg;
        cell_out.term_s = 33'(x5_reg);
        cell_out.term_c = dpwg_pkg::ONE_Q32;
        cell_out.sum_s  = 33'(x5_reg);
        cell_out.sum_c  = dpwg_pkg::ONE_Q32;
    end

endmodule

@@ rtl/dpwg_out.sv @@
// Output stage: octant signs, rounding to Q1.15, output register and skid word.
module dpwg_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dpwg_pkg::dpwg_cell_t cell_in,
    output logic                 en,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dpwg_pkg::dpwg_out_t  m_data
);

    localparam int WB    = dpwg_pkg::WEIGHT_BITS;
    localparam int SHIFT = 33 - WB;
    localparam logic [33:0] HALF = 34'd1 << (SHIFT - 1);
    localparam logic [WB-1:0] MAXV = {1'b0, {(WB - 1){1'b1}}};

    logic                m_valid_reg, m_valid_next;
    dpwg_pkg::dpwg_out_t m_data_reg, m_data_next;
    logic                skid_valid_reg, skid_valid_next;
    dpwg_pkg::dpwg_out_t skid_data_reg, skid_data_next;

    logic [32:0]         sq, cq;
    logic [32:0]         mag_re, mag_im;
    logic                neg_re, neg_im;
    dpwg_pkg::dpwg_out_t res;
    logic                take;

    function automatic logic [WB-1:0] to_weight(input logic [32:0] mag, input logic neg);
        logic [33:0]   sum;
        logic [33:0]   q;
        logic [WB-1:0] m;
        sum = {1'b0, mag} + HALF;
        q   = sum >> SHIFT;
        m   = (q > 34'(MAXV)) ? MAXV : q[WB-1:0];
        return neg ? (~m + 1'b1) : m;
    endfunction

    always_comb begin
        sq = cell_in.oct[0] ? cell_in.sum_c : cell_in.sum_s;
        cq = cell_in.oct[0] ? cell_in.sum_s : cell_in.sum_c;
        case (cell_in.oct[2:1])
            2'd0: begin
                mag_re = cq; neg_re = 1'b0;
                mag_im = sq; neg_im = 1'b1;
            end
            2'd1: begin
                mag_re = sq; neg_re = 1'b1;
                mag_im = cq; neg_im = 1'b1;
            end
            2'd2: begin
                mag_re = cq; neg_re = 1'b1;
                mag_im = sq; neg_im = 1'b0;
            end
            default: begin
                mag_re = sq; neg_re = 1'b0;
                mag_im = cq; neg_im = 1'b0;
            end
        endcase
        res.weight_real = to_weight(mag_re, neg_re);
        res.weight_imag = to_weight(mag_im, neg_im);
    end

    assign take = m_valid_reg && m_ready;
    assign en   = !skid_valid_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // pipeline frozen: drain the skid word
            if (take) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else begin
            if (take) begin
                m_valid_next = 1'b0;
            end
            if (cell_in.valid) begin
                if (!m_valid_reg || take) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                end else begin
                    skid_valid_next = 1'b1;
                    skid_data_next  = res;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/delay_phase_weight_generator.sv @@
// Top level of the delay phase weight generator: phase front end, five series cells, output.
// Each word passes the phase front end, the five series cells and the output register in turn.
// Throughput: one word per cycle; the pipeline holds only while the skid word is full.
// Reset (aresetn low, synchronous) empties the pipeline and output, loads the 80 MHz recip.
module delay_phase_weight_generator #(
    parameter int PHASE_BITS = dpwg_pkg::PHASE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dpwg_pkg::dpwg_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dpwg_pkg::dpwg_out_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [dpwg_pkg::RATE_W-1:0]   cfg_wr_data
);

    localparam int NC = dpwg_pkg::NUM_CELLS;

    logic [dpwg_pkg::RATE_W-1:0] inv_rate_reg, inv_rate_next;
    logic                        en;
    dpwg_pkg::dpwg_cell_t        chain [NC + 1];

    assign inv_rate_next = cfg_wr_en ? cfg_wr_data : inv_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_rate_reg <= dpwg_pkg::RATE_RESET;
        end else begin
            inv_rate_reg <= inv_rate_next;
        end
    end

    assign s_ready = en;

    dpwg_phase #(
        .PHASE_BITS(PHASE_BITS)
    ) u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .inv_rate (inv_rate_reg),
        .cell_out (chain[0])
    );

    for (genvar i = 0; i < NC; i++) begin : g_cell
        dpwg_taylor_cell #(
            .K(i + 1)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i + 1])
        );
    end

    dpwg_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cell_in (chain[NC]),
        .en      (en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ rtl/dpwg_checker.sv @@
// Port-level checks for the delay phase weight generator, bound to the top level.
`include "assert_macros.svh"

module dpwg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dpwg_pkg::dpwg_out_t m_data
);

    `DPWG_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid && s_ready, "reset left a word")
    `DPWG_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled word lost")
    `DPWG_ASSERT(a_stall_needs_word, !s_ready |-> m_valid, "input stalled with no word waiting")
    `DPWG_ASSERT(a_stall_cause, $fell(s_ready) |-> $past(m_valid && !m_ready), "input stalled unasked")

endmodule

bind delay_phase_weight_generator dpwg_checker u_dpwg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
